// ----- hw/rtl/deq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions of the double-ended queue
// Operation and status codes, field widths, default sizes and the command
// bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   // default sizes
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // port field widths
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // perform the store access and pointer update
   } deq_cmd_type;

endpackage : deq_pkg
`default_nettype wire

// ----- hw/rtl/deq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl: sequencing controller of the double-ended queue
// Runs each request through capture, store access and result hand-off, and
// takes the next request while a result still waits on the result channel.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output deq_pkg::deq_cmd_type   cmd
);
   import deq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;  // nothing held
   localparam logic [1:0] S_EXEC = 2'd1;  // store access cycle
   localparam logic [1:0] S_OUT  = 2'd2;  // result offered, request slot free
   localparam logic [1:0] S_HOLD = 2'd3;  // result offered, request pending

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // handshake and commands
   always_comb begin
      req_ready = (state_ff == S_IDLE) || (state_ff == S_OUT);
      rsp_valid = (state_ff == S_OUT) || (state_ff == S_HOLD);
      cmd.load  = req_valid && req_ready;
      cmd.exec  = (state_ff == S_EXEC);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (cmd.load && rsp_ready)       state_in = S_EXEC;
            else if (cmd.load)               state_in = S_HOLD;
            else if (rsp_ready)              state_in = S_IDLE;
         end
         S_HOLD: begin
            if (rsp_ready) state_in = S_EXEC;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_exec_then_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (!cmd.exec && rsp_valid))
      else $error("store access not followed by a result");

   a_no_load_in_exec: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.exec))
      else $error("request captured during store access");

   a_pending_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !req_ready) |=> cmd.exec)
      else $error("pending request not executed after result transfer");

   a_idle_load_runs: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !rsp_valid) |=> cmd.exec)
      else $error("request from idle not executed");

endmodule : deq_ctrl
`default_nettype wire

// ----- hw/rtl/deq_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deq_dpath: datapath of the double-ended queue
// Circular store with head pointer and entry count, request registers,
// wrap-around address adder and the result registers.
// ----------------------------------------------------------------------------
module deq_dpath #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire deq_pkg::deq_cmd_type            cmd,
   input  wire logic [deq_pkg::OP_W-1:0]        req_op,
   input  wire logic [deq_pkg::VALUE_W-1:0]     req_value,
   input  wire logic [deq_pkg::POS_W-1:0]       req_position,
   output logic      [deq_pkg::VALUE_W-1:0]     rsp_read_data,
   output logic      [deq_pkg::COUNT_W-1:0]     rsp_entry_count,
   output logic      [deq_pkg::STATUS_W-1:0]    rsp_status,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full
);
   import deq_pkg::*;

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // pointer
   localparam int CW   = $clog2(DEPTH + 1);                 // count
   localparam int SW   = PW + 1;                            // pointer sum
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;         // range compare

   // request registers
   logic [OP_W-1:0]       op_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [POS_W-1:0]      pos_ff;

   // queue state
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   // result registers
   logic [DATA_WIDTH-1:0] rd_ff;
   logic                  rd_sel_ff, rd_sel_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   // store
   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic          full, empty;
   logic [SW-1:0] offset, sum;
   logic [PW-1:0] wrapped, addr;
   logic          we, re;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= DATA_WIDTH'(req_value);
         pos_ff   <= req_position;
      end
   end

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // offset from the head for each operation
   always_comb begin
      case (op_ff)
         OP_PUSH_FRONT: offset = SW'(DEPTH - 1);
         OP_PUSH_BACK:  offset = SW'(count_ff);
         OP_POP_FRONT:  offset = SW'(1);
         OP_POP_BACK:   offset = SW'(count_ff) - SW'(1);
         OP_READ:       offset = SW'(pos_ff);
         default:       offset = '0;
      endcase
   end

   // wrap-around add, base below depth and offset at most depth
   always_comb begin
      sum     = SW'(head_ff) + offset;
      wrapped = (sum >= SW'(DEPTH)) ? PW'(sum - SW'(DEPTH)) : PW'(sum);
   end

   // operation decode
   always_comb begin
      we        = 1'b0;
      re        = 1'b0;
      addr      = wrapped;
      head_in   = head_ff;
      count_in  = count_ff;
      rd_sel_in = 1'b0;
      status_in = STAT_OK;
      case (op_ff)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = STAT_OVERFLOW;
            end else begin
               we       = 1'b1;
               head_in  = wrapped;
               count_in = count_ff + CW'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = STAT_OVERFLOW;
            end else begin
               we       = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = STAT_UNDERFLOW;
            end else begin
               re        = 1'b1;
               addr      = head_ff;
               head_in   = wrapped;
               count_in  = count_ff - CW'(1);
               rd_sel_in = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = STAT_UNDERFLOW;
            end else begin
               re        = 1'b1;
               count_in  = count_ff - CW'(1);
               rd_sel_in = 1'b1;
            end
         end
         OP_READ: begin
            if (CMPW'(pos_ff) >= CMPW'(count_ff)) begin
               status_in = STAT_RANGE;
            end else begin
               re        = 1'b1;
               rd_sel_in = 1'b1;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // store port, one address per cycle, registered read
   always_ff @(posedge clock) begin
      if (cmd.exec && we) mem[addr] <= value_ff;
      if (cmd.exec && re) rd_ff <= mem[addr];
   end

   // pointer and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // result status
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_sel_ff <= rd_sel_in;
         status_ff <= status_in;
      end
   end

   // result fields
   assign rsp_read_data   = rd_sel_ff ? VALUE_W'(rd_ff) : '0;
   assign rsp_entry_count = COUNT_W'(count_ff);
   assign rsp_status      = status_ff;
   assign rsp_is_empty    = empty;
   assign rsp_is_full     = full;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(head_ff) < SW'(DEPTH))
      else $error("head pointer outside store");

endmodule : deq_dpath
`default_nettype wire

// ----- hw/rtl/double_ended_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue
// Push and pop at either end and read by position over a circular store.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. A request is taken into a request
// register, runs its store access on the single-port circular store (write
// for a push, registered read for a pop or a positional read, pointer and
// count update), and its result is then offered from registers. The next
// request is taken while that result waits, and its store access starts once
// that result has been transferred; from idle a request passes through the
// store access state before its result is offered. Errors (pop when empty,
// push when full, position at or beyond the count) leave the queue unchanged
// and return zero data. No clearing pass runs after reset; only held entries
// are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [deq_pkg::OP_W-1:0]        req_op,
   input  wire logic [deq_pkg::VALUE_W-1:0]     req_value,
   input  wire logic [deq_pkg::POS_W-1:0]       req_position,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [deq_pkg::VALUE_W-1:0]     rsp_read_data,
   output logic      [deq_pkg::COUNT_W-1:0]     rsp_entry_count,
   output logic      [deq_pkg::STATUS_W-1:0]    rsp_status,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full
);
   import deq_pkg::*;

   deq_cmd_type cmd;

   // sequencing
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // store and pointers
   deq_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_read_data   (rsp_read_data),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule : double_ended_queue
`default_nettype wire
